// ===== rtl/hsec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsec_pkg
// Widths, reset values and parity helpers for the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsec_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int MAX_CODE_BITS = 63;
    localparam int LEN_W         = 6;
    localparam int SYN_W         = 6;

    localparam logic [LEN_W-1:0] DATA_LEN_RESET = 6'd4;
    localparam logic [LEN_W-1:0] CODE_LEN_RESET = 6'd7;

    typedef logic [MAX_DATA_BITS-1:0] data_t;
    typedef logic [MAX_CODE_BITS-1:0] code_t;
    typedef logic [SYN_W-1:0]         syn_t;

    typedef enum logic
    {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    // data bit k lands on the k-th position that is not a power of two
    function automatic code_t place_data(input data_t d);
        code_t w;
        int    k;
        w = '0;
        k = 0;
        for (int pos = 1; pos <= MAX_CODE_BITS; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (k < MAX_DATA_BITS)
                begin
                    w[pos-1] = d[k];
                end
                k++;
            end
        end
        return w;
    endfunction

    // xor of the indices of all one bits, built as one parity tree per bit
    function automatic syn_t syndrome_of(input code_t w);
        syn_t s;
        s = '0;
        for (int b = 0; b < SYN_W; b++)
        begin
            for (int pos = 1; pos <= MAX_CODE_BITS; pos++)
            begin
                if (((pos >> b) & 1) != 0)
                begin
                    s[b] = s[b] ^ w[pos-1];
                end
            end
        end
        return s;
    endfunction

    // number of parity bits for m data bits
    function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] m);
        logic [2:0] r;
        if (m <= 6'd1)
        begin
            r = 3'd2;
        end
        else if (m <= 6'd4)
        begin
            r = 3'd3;
        end
        else if (m <= 6'd11)
        begin
            r = 3'd4;
        end
        else if (m <= 6'd26)
        begin
            r = 3'd5;
        end
        else
        begin
            r = 3'd6;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hamming_sec_encode_correct_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct_top
// Hamming single-error-correcting encoder and corrector, configurable length.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  command   start, busy, func, data_word, code_word   in (busy out)
//  result    done, code_out, syndrome, corrected       out
//  config    cfg_valid, cfg_ready, cfg_data            in (cfg_ready out)
//
//  one transaction per cycle; the result strobe follows start through the
//  input register, then parity trees and correction into the result register
//  busy and cfg_ready stay low and high; the length masks are rebuilt on a
//  config write, so no cycle is lost to length decoding
//  reset brings data_length to 4 (7-bit codeword) and clears the strobes
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct_top
    import hsec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic [MAX_DATA_BITS-1:0] data_word,
    input  logic [MAX_CODE_BITS-1:0] code_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LEN_W-1:0]         cfg_data,
    output logic                     done,
    output logic [MAX_CODE_BITS-1:0] code_out,
    output logic [SYN_W-1:0]         syndrome,
    output logic                     corrected
);

    // length configuration, held as masks
    data_t            data_mask_reg, data_mask_next;
    code_t            code_mask_reg, code_mask_next;
    logic [LEN_W-1:0] code_len_reg, code_len_next;
    logic [LEN_W-1:0] m_clamped;

    // input stage
    logic  in_valid_reg;
    func_t func_reg;
    data_t data_reg;
    code_t code_reg;

    // result stage
    logic  done_reg;
    code_t code_out_reg, code_out_next;
    syn_t  syndrome_reg, syndrome_next;
    logic  corrected_reg, corrected_next;

    code_t enc_word;
    syn_t  enc_par;
    code_t dec_word;
    syn_t  dec_syn;
    code_t flip_vec;
    logic  flip;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            m_clamped = 6'd1;
        end
        else if (cfg_data > LEN_W'(MAX_DATA_BITS))
        begin
            m_clamped = LEN_W'(MAX_DATA_BITS);
        end
        else
        begin
            m_clamped = cfg_data;
        end
        code_len_next = m_clamped + LEN_W'(parity_count(m_clamped));
        for (int i = 0; i < MAX_DATA_BITS; i++)
        begin
            data_mask_next[i] = (LEN_W'(i) < m_clamped);
        end
        for (int i = 0; i < MAX_CODE_BITS; i++)
        begin
            code_mask_next[i] = (LEN_W'(i) < code_len_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mask_reg <= data_t'((64'd1 << DATA_LEN_RESET) - 64'd1);
            code_mask_reg <= code_t'((64'd1 << CODE_LEN_RESET) - 64'd1);
            code_len_reg  <= CODE_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            data_mask_reg <= data_mask_next;
            code_mask_reg <= code_mask_next;
            code_len_reg  <= code_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func_t'(func);
            data_reg <= data_word;
            code_reg <= code_word;
        end
        if (in_valid_reg)
        begin
            code_out_reg  <= code_out_next;
            syndrome_reg  <= syndrome_next;
            corrected_reg <= corrected_next;
        end
    end

    // encode: place data, then fold the parity bits into the power-of-two slots
    always_comb
    begin
        enc_word = place_data(data_reg & data_mask_reg);
        enc_par  = syndrome_of(enc_word);
        for (int b = 0; b < SYN_W; b++)
        begin
            enc_word[(1 << b) - 1] = enc_par[b];
        end
    end

    // decode: syndrome, then flip the named position if it lies in the code
    always_comb
    begin
        dec_word = code_reg & code_mask_reg;
        dec_syn  = syndrome_of(dec_word);
        flip     = (dec_syn != '0) && (dec_syn <= code_len_reg);
        for (int i = 0; i < MAX_CODE_BITS; i++)
        begin
            flip_vec[i] = flip && (dec_syn == SYN_W'(i + 1));
        end
    end

    always_comb
    begin
        case (func_reg)
            FUNC_ENCODE:
            begin
                code_out_next  = enc_word & code_mask_reg;
                syndrome_next  = '0;
                corrected_next = 1'b0;
            end
            FUNC_DECODE:
            begin
                code_out_next  = (dec_word ^ flip_vec) & code_mask_reg;
                syndrome_next  = dec_syn;
                corrected_next = flip;
            end
            default:
            begin
                code_out_next  = '0;
                syndrome_next  = '0;
                corrected_next = 1'b0;
            end
        endcase
    end

    assign done      = done_reg;
    assign code_out  = code_out_reg;
    assign syndrome  = syndrome_reg;
    assign corrected = corrected_reg;

endmodule

// ===== tb/sv/tb_hamming_sec_encode_correct_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_sec_encode_correct_top
// Self-checking bench for the configurable Hamming SEC encoder / corrector.
// Encode and correct commands run over many data lengths, extremes included,
// with random sender gaps and back-to-back streams. Each codeword, syndrome
// and correction flag is predicted in the bench and compared with the block.
// ----------------------------------------------------------------------------
module tb_hamming_sec_encode_correct_top;
    import hsec_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 12;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_CYC   = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 30;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 115;

    typedef struct packed
    {
        code_t code;
        syn_t  syn;
        logic  fixed;
    } hsec_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    func_t            func      = FUNC_ENCODE;
    data_t            data_word = '0;
    code_t            code_word = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data  = '0;
    logic             done;
    code_t            code_out;
    syn_t             syndrome;
    logic             corrected;

    // length seen by the predictor, and the one the stimulus side builds for
    logic [LEN_W-1:0] len_shadow = DATA_LEN_RESET;
    logic [LEN_W-1:0] cur_len    = DATA_LEN_RESET;

    hsec_result_t expected_q[$];
    int           gap_max     = MAX_GAP;
    int           mismatches  = 0;
    int           n_encode    = 0;
    int           n_decode    = 0;
    int           n_fixed     = 0;
    int           n_beyond    = 0;
    int           n_lengths   = 0;
    int           stall_count = 0;

    hamming_sec_encode_correct_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .data_word (data_word),
        .code_word (code_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .code_out  (code_out),
        .syndrome  (syndrome),
        .corrected (corrected)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int active_bits(input logic [LEN_W-1:0] len);
        int m;
        m = len;
        if (m < 1)
            m = 1;
        if (m > MAX_DATA_BITS)
            m = MAX_DATA_BITS;
        return m;
    endfunction

    function automatic int code_bits(input int m);
        int r;
        int n;
        r = 0;
        while (r < 7 && (1 << r) < m + r + 1)
            r++;
        n = m + r;
        if (n > MAX_CODE_BITS)
            n = MAX_CODE_BITS;
        return n;
    endfunction

    function automatic code_t len_mask(input int n);
        return code_t'((64'd1 << n) - 64'd1);
    endfunction

    function automatic syn_t index_xor(input code_t w, input int n);
        syn_t s;
        s = '0;
        for (int pos = 1; pos <= n; pos++)
            if (w[pos-1])
                s ^= syn_t'(pos);
        return s;
    endfunction

    function automatic code_t hamming_encode(input data_t d, input int m, input int n);
        code_t w;
        syn_t  p;
        int    k;
        w = '0;
        k = 0;
        for (int pos = 1; pos <= n; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (k < m && d[k])
                    w[pos-1] = 1'b1;
                k++;
            end
        end
        // parity at power-of-two positions zeroes the index xor
        p = index_xor(w, n);
        for (int b = 0; b < SYN_W; b++)
            if ((1 << b) <= n && p[b])
                w[(1 << b) - 1] = 1'b1;
        return w;
    endfunction

    function automatic hsec_result_t hamming_predict(input func_t f, input data_t d,
                                                     input code_t c,
                                                     input logic [LEN_W-1:0] len);
        hsec_result_t res;
        int           m;
        int           n;
        m   = active_bits(len);
        n   = code_bits(m);
        res = '0;
        if (f == FUNC_ENCODE)
        begin
            res.code = hamming_encode(d, m, n);
        end
        else
        begin
            res.code = c & len_mask(n);
            res.syn  = index_xor(res.code, n);
            if (res.syn != 0 && res.syn <= n)
            begin
                res.code[res.syn - 1] = ~res.code[res.syn - 1];
                res.fixed = 1'b1;
            end
        end
        res.code &= len_mask(n);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, want);
    endtask

    // accepted commands are predicted first, so a result can never overtake them
    always @(posedge clk)
    begin
        hsec_result_t pred;
        hsec_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pred = hamming_predict(func, data_word, code_word, len_shadow);
                expected_q = {expected_q, pred};
                if (func == FUNC_ENCODE)
                    n_encode++;
                else
                    n_decode++;
                if (pred.fixed)
                    n_fixed++;
                else if (pred.syn != 0)
                    n_beyond++;
            end
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(code_out), 64'd0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (code_out !== want.code)
                        report_mismatch("code_out", 64'(code_out), 64'(want.code));
                    if (syndrome !== want.syn)
                        report_mismatch("syndrome", 64'(syndrome), 64'(want.syn));
                    if (corrected !== want.fixed)
                        report_mismatch("corrected", 64'(corrected), 64'(want.fixed));
                end
            end
            if (cfg_valid && cfg_ready)
                len_shadow <= cfg_data;

            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_item(input func_t f, input data_t d, input code_t c);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        data_word <= d;
        code_word <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic data_t rand_data();
        return data_t'({$urandom, $urandom});
    endfunction

    function automatic code_t rand_code();
        return code_t'({$urandom, $urandom});
    endfunction

    function automatic code_t flip_pos(input code_t w, input int pos);
        w[pos-1] = ~w[pos-1];
        return w;
    endfunction

    task automatic send_encode(input data_t d);
        send_item(FUNC_ENCODE, d, rand_code());
    endtask

    task automatic send_decode(input code_t c);
        send_item(FUNC_DECODE, rand_data(), c);
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_len = len;
        n_lengths++;
    endtask

    task automatic send_random(input int count);
        int    m;
        int    n;
        int    sel;
        code_t w;
        m = active_bits(cur_len);
        n = code_bits(m);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 3)
            begin
                send_encode(rand_data());
            end
            else if (sel <= 8)
            begin
                // well-formed codeword, mostly with one bit hit
                w = hamming_encode(rand_data(), m, n);
                if ($urandom_range(0, 4) != 0)
                    w = flip_pos(w, $urandom_range(1, n));
                if (sel == 8)
                    w |= rand_code() & ~len_mask(n);
                send_decode(w);
            end
            else
            begin
                send_decode(rand_code());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_length();
        code_t w;
        w = hamming_encode(57'b1011, 4, 7);
        send_encode('0);
        send_encode('1);
        send_encode(57'b1011);
        send_decode(w);
        send_decode(flip_pos(w, 1));
        send_decode(flip_pos(w, 3));
        send_decode(flip_pos(w, 7));
        send_decode('1);
    endtask

    task automatic test_length_extremes();
        code_t w;
        write_length(6'd0);
        send_encode('1);
        send_decode('1);
        write_length(6'd63);
        send_encode('1);
        send_decode('1);
        write_length(6'd57);
        w = hamming_encode(57'd1 << 56, 57, 63);
        send_encode(57'd1 << 56);
        send_decode(flip_pos(w, 63));
        send_decode(flip_pos(w, 32));
        send_decode('0);
    endtask

    // nonzero syndromes past the end of the code are reported, not applied
    task automatic test_syndrome_beyond_code();
        write_length(6'd5);
        send_decode(63'b1000_1010);
        send_decode(63'b1_0000_0001);
        write_length(6'd12);
        send_decode(63'h1_0002);
        send_decode(63'h1_0001);
    endtask

    task automatic test_random_traffic();
        int lens[12] = '{1, 57, 63, 0, 2, 4, 11, 12, 26, 27, 58, 5};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 12)
                write_length(LEN_W'(lens[ph]));
            else
                write_length(LEN_W'($urandom_range(0, 63)));
            gap_max = (ph % 4 == 1) ? 0 : MAX_GAP;
            send_random(PHASE_ITEMS);
        end
        gap_max = MAX_GAP;
    endtask

    task automatic test_streaming();
        write_length(6'd57);
        gap_max = 0;
        send_random(150);
        gap_max = MAX_GAP;
    endtask

    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_length_extremes();
        test_syndrome_beyond_code();
        test_random_traffic();
        test_streaming();
        drain();

        $display("covered %0d encodes and %0d decodes over %0d length settings",
                 n_encode, n_decode, n_lengths);
        $display("decodes: %0d single-bit corrections, %0d syndromes past the code end",
                 n_fixed, n_beyond);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsec_pkg.sv
rtl/hamming_sec_encode_correct_top.sv
tb/sv/tb_hamming_sec_encode_correct_top.sv
